[design/ckc2d_pkg.sv]
// ----------------------------------------------------------------------------
// ckc2d_pkg
// Shared types and constants for the 3x3 complex-kernel convolution core.
// ----------------------------------------------------------------------------
package ckc2d_pkg;

    localparam int PIX_W         = 8;
    localparam int POS_W         = 10;
    localparam int SUM_OUT_W     = 20;
    localparam int IMG_DIM_W     = 11;
    localparam int KREG_W        = 24;
    localparam int KSIZE         = 3;
    localparam int NUM_TAPS      = KSIZE * KSIZE;
    localparam int NUM_KREGS     = 2 * KSIZE;
    localparam int NUM_REGS      = 2 + NUM_KREGS;
    localparam int REG_IDX_W     = $clog2(NUM_REGS);
    localparam int APB_ADDR_W    = REG_IDX_W + 2;
    localparam int APB_DATA_W    = 32;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_DIM       = 3;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_COEF_BITS = 8;

    localparam logic [IMG_DIM_W-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [IMG_DIM_W-1:0] HEIGHT_RESET = 11'd240;

    // register map (index = byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KREAL_ROW0   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KREAL_ROW1   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KREAL_ROW2   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KIMAG_ROW0   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_KIMAG_ROW1   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_KIMAG_ROW2   = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic signed [SUM_OUT_W-1:0] real_sum;
        logic signed [SUM_OUT_W-1:0] imag_sum;
        logic        [POS_W-1:0]     out_row;
        logic        [POS_W-1:0]     out_col;
        logic                        frame_last;
    } result_t;

    // travels alongside a window through the arithmetic stages
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } tag_t;

    // tap r*KSIZE+c: window row r (0 = top), column c (0 = oldest)
    typedef logic [NUM_TAPS-1:0][PIX_W-1:0] window_t;

    // real rows 0..2 then imaginary rows 0..2
    typedef logic [NUM_KREGS-1:0][KREG_W-1:0] kregs_t;

endpackage

[design/ckc2d_line_store.sv]
// ----------------------------------------------------------------------------
// ckc2d_line_store
// Two-row line buffer: one entry per column, row-2 pixel in the high byte and
// row-1 pixel in the low byte. Registered read with write-to-read bypass.
// ----------------------------------------------------------------------------
module ckc2d_line_store
    import ckc2d_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic [2*PIX_W-1:0]           rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [2*PIX_W-1:0]           wr_data
);

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a read of the column being written this cycle takes the new data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/ckc2d_mac.sv]
// ----------------------------------------------------------------------------
// ckc2d_mac
// Complex multiply-accumulate over a 3x3 window: one register stage of
// products, one of sums, both advanced by the pipeline enable.
// ----------------------------------------------------------------------------
module ckc2d_mac
    import ckc2d_pkg::*;
#(
    parameter int COEF_BITS = DEF_COEF_BITS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  window_t win,
    input  kregs_t  kregs,
    input  tag_t    tag_in,
    output logic    res_valid,
    output result_t res
);

    localparam int PROD_W = PIX_W + 1 + COEF_BITS;
    localparam int SUM_W  = PROD_W + 4;
    localparam int EXT_W  = KREG_W + KSIZE * COEF_BITS;

    logic signed [COEF_BITS-1:0] coef_re [NUM_TAPS];
    logic signed [COEF_BITS-1:0] coef_im [NUM_TAPS];
    logic signed [PROD_W-1:0]    re_prod_next [NUM_TAPS];
    logic signed [PROD_W-1:0]    im_prod_next [NUM_TAPS];
    logic signed [PROD_W-1:0]    re_prod_reg  [NUM_TAPS];
    logic signed [PROD_W-1:0]    im_prod_reg  [NUM_TAPS];
    tag_t                        tag_reg;
    logic signed [SUM_W-1:0]     re_acc;
    logic signed [SUM_W-1:0]     im_acc;
    logic signed [SUM_W+SUM_OUT_W-1:0] re_ext;
    logic signed [SUM_W+SUM_OUT_W-1:0] im_ext;
    logic                        res_valid_reg;
    result_t                     res_reg;
    result_t                     res_next;

    // unpack coefficients; columns past the register width read as zero
    always_comb begin
        logic [EXT_W-1:0] ext_re;
        logic [EXT_W-1:0] ext_im;
        for (int r = 0; r < KSIZE; r++) begin
            ext_re = EXT_W'(kregs[r]);
            ext_im = EXT_W'(kregs[KSIZE + r]);
            for (int c = 0; c < KSIZE; c++) begin
                coef_re[r*KSIZE + c] = $signed(ext_re[c*COEF_BITS +: COEF_BITS]);
                coef_im[r*KSIZE + c] = $signed(ext_im[c*COEF_BITS +: COEF_BITS]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            re_prod_next[k] = PROD_W'($signed({1'b0, win[k]})) * PROD_W'(coef_re[k]);
            im_prod_next[k] = PROD_W'($signed({1'b0, win[k]})) * PROD_W'(coef_im[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                re_prod_reg[k] <= re_prod_next[k];
                im_prod_reg[k] <= im_prod_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= tag_in;
        end
    end

    always_comb begin
        re_acc = '0;
        im_acc = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            re_acc = re_acc + SUM_W'(re_prod_reg[k]);
            im_acc = im_acc + SUM_W'(im_prod_reg[k]);
        end
        re_ext = (SUM_W + SUM_OUT_W)'(re_acc);
        im_ext = (SUM_W + SUM_OUT_W)'(im_acc);
        res_next.real_sum   = re_ext[SUM_OUT_W-1:0];
        res_next.imag_sum   = im_ext[SUM_OUT_W-1:0];
        res_next.out_row    = tag_reg.row;
        res_next.out_col    = tag_reg.col;
        res_next.frame_last = tag_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (en) begin
            res_valid_reg <= tag_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[design/complex_kernel_convolution_2d_core.sv]
// ----------------------------------------------------------------------------
// complex_kernel_convolution_2d_core
// Streaming 3x3 complex-kernel correlation over the valid region of a frame.
// ----------------------------------------------------------------------------
// Accepts one 8-bit pixel per clock in raster order unless stalled and returns
// one result per pixel whose window is complete (row and column both at least
// 2): the real and imaginary sums of pixel times signed Q4.4 coefficient, in
// 1/16 units, tagged with the window's top-left position. A pixel passes the
// stage-1, window, product and result registers; the pipeline advances as a
// whole whenever the result register is empty or being taken. The line store
// is a MAX_WIDTH x 16 memory, one write and one registered read per clock when
// advancing; its contents are undefined after reset and need no clearing, as
// the first two rows of each frame refill it before any result depends on it.
// Sizes in use clamp to 3..MAX_WIDTH and 3..1024. The user writes configuration
// through the APB port while no transaction is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module complex_kernel_convolution_2d_core
    import ckc2d_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int COEF_BITS = DEF_COEF_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // pixel input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_in_t             s_data,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW + 1 > IMG_DIM_W) ? AW + 1 : IMG_DIM_W;

    // configuration registers
    logic [IMG_DIM_W-1:0] image_width_reg;
    logic [IMG_DIM_W-1:0] image_height_reg;
    kregs_t               kregs_reg;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    // position counters
    logic [AW-1:0]        col_count_reg;
    logic [AW-1:0]        col_count_next;
    logic [POS_W-1:0]     row_count_reg;
    logic [POS_W-1:0]     row_count_next;

    logic                 en;
    logic                 accept;
    logic [CW-1:0]        w_lim;
    logic [IMG_DIM_W-1:0] h_lim;
    logic [AW-1:0]        col_cur;
    logic [AW-1:0]        col;
    logic [POS_W-1:0]     row;
    logic                 row_end;
    logic                 frame_end;
    tag_t                 tag_next;

    // stage 1: pixel waiting for its line-store read
    logic                 p1_valid_reg;
    logic [PIX_W-1:0]     p1_pixel_reg;
    logic [AW-1:0]        p1_col_reg;
    tag_t                 p1_tag_reg;
    logic [2*PIX_W-1:0]   rd_data;
    logic                 ls_wr_en;

    // stage 2: window and its tag
    window_t              win_reg;
    window_t              win_next;
    tag_t                 t2_tag_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign accept  = s_valid && en;
    assign pready  = 1'b1;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            kregs_reg        <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[IMG_DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[IMG_DIM_W-1:0];
                REG_KREAL_ROW0:   kregs_reg[0]     <= pwdata[KREG_W-1:0];
                REG_KREAL_ROW1:   kregs_reg[1]     <= pwdata[KREG_W-1:0];
                REG_KREAL_ROW2:   kregs_reg[2]     <= pwdata[KREG_W-1:0];
                REG_KIMAG_ROW0:   kregs_reg[3]     <= pwdata[KREG_W-1:0];
                REG_KIMAG_ROW1:   kregs_reg[4]     <= pwdata[KREG_W-1:0];
                REG_KIMAG_ROW2:   kregs_reg[5]     <= pwdata[KREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            REG_KREAL_ROW0:   prdata = APB_DATA_W'(kregs_reg[0]);
            REG_KREAL_ROW1:   prdata = APB_DATA_W'(kregs_reg[1]);
            REG_KREAL_ROW2:   prdata = APB_DATA_W'(kregs_reg[2]);
            REG_KIMAG_ROW0:   prdata = APB_DATA_W'(kregs_reg[3]);
            REG_KIMAG_ROW1:   prdata = APB_DATA_W'(kregs_reg[4]);
            REG_KIMAG_ROW2:   prdata = APB_DATA_W'(kregs_reg[5]);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // position tracking
    // ------------------------------------------------------------------
    always_comb begin
        if (CW'(image_width_reg) < CW'(MIN_DIM)) begin
            w_lim = CW'(MIN_DIM);
        end else if (CW'(image_width_reg) > CW'(MAX_WIDTH)) begin
            w_lim = CW'(MAX_WIDTH);
        end else begin
            w_lim = CW'(image_width_reg);
        end

        if (image_height_reg < IMG_DIM_W'(MIN_DIM)) begin
            h_lim = IMG_DIM_W'(MIN_DIM);
        end else if (image_height_reg > IMG_DIM_W'(MAX_HEIGHT)) begin
            h_lim = IMG_DIM_W'(MAX_HEIGHT);
        end else begin
            h_lim = image_height_reg;
        end

        col_cur = s_data.frame_start ? '0 : col_count_reg;
        row     = s_data.frame_start ? '0 : row_count_reg;

        // a column past a lowered width ends the row at once
        if (CW'(col_cur) >= w_lim) begin
            col = AW'(w_lim - CW'(1));
        end else begin
            col = col_cur;
        end

        row_end   = (CW'(col) >= w_lim - CW'(1));
        frame_end = row_end && (IMG_DIM_W'(row) >= h_lim - IMG_DIM_W'(1));

        if (frame_end) begin
            col_count_next = '0;
            row_count_next = '0;
        end else if (row_end) begin
            col_count_next = '0;
            row_count_next = row + POS_W'(1);
        end else begin
            col_count_next = col + AW'(1);
            row_count_next = row;
        end

        tag_next.valid = (row >= POS_W'(2)) && (col >= AW'(2));
        tag_next.row   = row - POS_W'(2);
        tag_next.col   = POS_W'(CW'(col) - CW'(2));
        tag_next.last  = frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: line-store read
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pixel_reg <= s_data.pixel;
            p1_col_reg   <= col;
            p1_tag_reg   <= tag_next;
        end
    end

    assign ls_wr_en = en && p1_valid_reg;

    ckc2d_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (rd_data),
        .wr_en   (ls_wr_en),
        .wr_addr (p1_col_reg),
        .wr_data ({rd_data[PIX_W-1:0], p1_pixel_reg})
    );

    // ------------------------------------------------------------------
    // stage 2: window shift
    // ------------------------------------------------------------------
    always_comb begin
        win_next = win_reg;
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE - 1; c++) begin
                win_next[r*KSIZE + c] = win_reg[r*KSIZE + c + 1];
            end
        end
        win_next[KSIZE - 1]         = rd_data[2*PIX_W-1:PIX_W];
        win_next[2*KSIZE - 1]       = rd_data[PIX_W-1:0];
        win_next[KSIZE*KSIZE - 1]   = p1_pixel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (ls_wr_en) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t2_tag_reg <= '0;
        end else if (en) begin
            // drop the tag of an empty slot
            t2_tag_reg <= '{valid: p1_valid_reg && p1_tag_reg.valid,
                            row:   p1_tag_reg.row,
                            col:   p1_tag_reg.col,
                            last:  p1_tag_reg.last};
        end
    end

    // ------------------------------------------------------------------
    // stages 3 and 4: products, sums, result register
    // ------------------------------------------------------------------
    ckc2d_mac #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .win       (win_reg),
        .kregs     (kregs_reg),
        .tag_in    (t2_tag_reg),
        .res_valid (m_valid),
        .res       (m_data)
    );

endmodule
